>>> hdl/e2c_pkg.sv
`timescale 1ns / 1ps
package e2c_pkg;

  localparam int SECS_W = 39;
  localparam int FRAC_W = 16;

  typedef struct packed {
    logic signed [SECS_W-1:0] epoch_seconds;
    logic [FRAC_W-1:0]        epoch_fraction;
  } e2c_in_t;

  typedef struct packed {
    logic [13:0]       year;
    logic [3:0]        month;
    logic [4:0]        day_of_month;
    logic [8:0]        day_of_year;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [FRAC_W-1:0] second_fraction;
    logic              out_of_range;
  } e2c_out_t;

  // Valid span: years 1 through 9999
  localparam logic signed [SECS_W-1:0] EPOCH_MIN = -39'sd62135596800;
  localparam logic signed [SECS_W-1:0] EPOCH_MAX = 39'sd253402300799;

  localparam logic [16:0] SEC_DAY       = 17'd86400;
  localparam logic [9:0]  DAY_HI        = 10'd675;   // 86400 / 128
  localparam logic [16:0] SEC_HOUR      = 17'd3600;
  localparam logic [11:0] SEC_MIN       = 12'd60;
  localparam logic [22:0] DAYS_TO_MAR0  = 23'd719468;
  localparam logic [21:0] DAYS_ERA      = 22'd146097;
  localparam logic [17:0] DAYS_ERA_LAST = 18'd146096;
  localparam logic [18:0] DAYS_YEAR     = 19'd365;
  localparam logic [13:0] YEARS_ERA     = 14'd400;
  localparam logic [8:0]  DOY_MAR_OFS   = 9'd60;     // day of year of March 1, common year
  localparam logic [8:0]  DOY_JAN_OFS   = 9'd305;    // days from March 1 to next January 1, less one

  // Reciprocals: floor(x / d) == (x * ceil(2^s / d)) >> s over the operand width
  localparam logic [31:0] RCP_DAY  = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
  localparam logic [17:0] RCP_HOUR = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] RCP_MIN  = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam logic [22:0] RCP_ERA  = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
  localparam logic [18:0] RCP_4Y   = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] RCP_100Y = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] RCP_YEAR = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [12:0] RCP_MON  = 13'(((64'd1 << 20) + 64'd152) / 64'd153);

  // First day of each month counted from March 1
  function automatic logic [8:0] mar_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/epoch_to_calendar.sv
`timescale 1ns / 1ps
// Epoch seconds to Gregorian calendar date and time of day.
//
// Input channel (in_valid/in_ready/in_data) takes a signed 39-bit count of whole
// seconds since 1970-01-01 00:00:00 plus a 16-bit binary fraction of a second.
// Output channel (out_valid/out_ready/out_data) returns year, month, day of
// month, day of year, hour, minute, second, the fraction and an out-of-range
// flag. Times before 1970 use floor division, so the time of day is nonnegative.
// Outside years 1..9999 the date fields read zero; the time of day is kept.
//
// One request is taken every cycle unless the receiver holds a waiting
// result. No path in a stage passes through more than one constant-reciprocal
// multiply (the 4-year and 100-year divisions sit side by side in one stage),
// so the depth is set by the chain of divisions (by day, era, 4/100 years,
// year, month) on the date path, with the time-of-day path running alongside.
// Reset (rst_n low at a clock edge) empties the pipeline: all valid bits drop.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes in place and in_ready drops; nothing is lost or repeated.
module epoch_to_calendar #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  e2c_pkg::e2c_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output e2c_pkg::e2c_out_t  out_data
);

  localparam int NS   = 13;
  localparam int KEEP = (FRACTION_BITS < e2c_pkg::FRAC_W) ? FRACTION_BITS : e2c_pkg::FRAC_W;

  logic [NS-1:0] vld_r;
  logic          adv;

  // Advance every stage together unless the result register is held
  assign adv       = out_ready | ~vld_r[NS-1];
  assign in_ready  = adv;
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  // Side lines: fraction and range flag ride along stages 1..12
  logic [e2c_pkg::FRAC_W-1:0] frac_nxt;
  logic [e2c_pkg::FRAC_W-1:0] frac_r [NS-1];
  logic                       oor_nxt;
  logic                       oor_r  [NS-1];

  // ---------------- stage 1: fold sign, range check ----------------
  logic signed [e2c_pkg::SECS_W-1:0] secs;
  logic [37:0] mag;
  logic [30:0] s1_hi_nxt, s1_hi_r;
  logic [6:0]  s1_lo_nxt, s1_lo_r;
  logic        s1_neg_r;

  assign secs = in_data.epoch_seconds;
  // Negative input: work on ~secs, then mirror quotient and remainder back
  assign mag       = secs[38] ? ~secs[37:0] : secs[37:0];
  assign s1_hi_nxt = mag[37:7];
  assign s1_lo_nxt = mag[6:0];
  assign oor_nxt   = (secs < e2c_pkg::EPOCH_MIN) || (secs > e2c_pkg::EPOCH_MAX);

  always_comb begin
    for (int i = 0; i < e2c_pkg::FRAC_W; i++) begin
      frac_nxt[i] = in_data.epoch_fraction[i] & (i < KEEP);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_hi_r   <= s1_hi_nxt;
      s1_lo_r   <= s1_lo_nxt;
      s1_neg_r  <= secs[38];
      frac_r[0] <= frac_nxt;
      oor_r[0]  <= oor_nxt;
      for (int i = 1; i < NS - 1; i++) begin
        frac_r[i] <= frac_r[i-1];
        oor_r[i]  <= oor_r[i-1];
      end
    end
  end

  // ---------------- stage 2: divide by 675 (86400 = 675 * 128) ----------------
  logic [62:0] prod_day;
  logic [21:0] s2_q_nxt, s2_q_r;
  logic [9:0]  s2_hi_r;
  logic [6:0]  s2_lo_r;
  logic        s2_neg_r;

  assign prod_day = 63'(s1_hi_r) * 63'(e2c_pkg::RCP_DAY);
  assign s2_q_nxt = prod_day[62:41];

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_q_r   <= s2_q_nxt;
      s2_hi_r  <= s1_hi_r[9:0];
      s2_lo_r  <= s1_lo_r;
      s2_neg_r <= s1_neg_r;
    end
  end

  // ---------------- stage 3: second of day, signed day number ----------------
  logic [31:0] qm;
  logic [9:0]  rem_d;
  logic [16:0] sod_m;
  logic [16:0] s3_sod_nxt, s3_sod_r;
  logic [22:0] s3_days_nxt, s3_days_r;

  // Remainder is below 675, so ten low bits carry it exactly
  assign qm          = 32'(s2_q_r) * 32'(e2c_pkg::DAY_HI);
  assign rem_d       = s2_hi_r - qm[9:0];
  assign sod_m       = {rem_d, s2_lo_r};
  assign s3_sod_nxt  = s2_neg_r ? (e2c_pkg::SEC_DAY - 17'd1 - sod_m) : sod_m;
  assign s3_days_nxt = s2_neg_r ? ~{1'b0, s2_q_r} : {1'b0, s2_q_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sod_r  <= s3_sod_nxt;
      s3_days_r <= s3_days_nxt;
    end
  end

  // ---------------- stage 4: shift to March-based days, hour ----------------
  logic [34:0] prod_h;
  logic [21:0] s4_z_nxt, s4_z_r;
  logic [4:0]  s4_hour_nxt, s4_hour_r;
  logic [16:0] s4_sod_r;

  assign s4_z_nxt    = 22'(s3_days_r + e2c_pkg::DAYS_TO_MAR0);
  assign prod_h      = 35'(s3_sod_r) * 35'(e2c_pkg::RCP_HOUR);
  assign s4_hour_nxt = prod_h[33:29];

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_z_r    <= s4_z_nxt;
      s4_hour_r <= s4_hour_nxt;
      s4_sod_r  <= s3_sod_r;
    end
  end

  // ---------------- stage 5: era, second of hour ----------------
  logic [44:0] prod_era;
  logic [16:0] hsec;
  logic [4:0]  s5_era_nxt, s5_era_r;
  logic [11:0] s5_remh_nxt, s5_remh_r;
  logic [21:0] s5_z_r;
  logic [4:0]  s5_hour_r;

  assign prod_era    = 45'(s4_z_r) * 45'(e2c_pkg::RCP_ERA);
  assign s5_era_nxt  = prod_era[44:40];
  assign hsec        = 17'(s4_hour_r) * e2c_pkg::SEC_HOUR;
  assign s5_remh_nxt = 12'(s4_sod_r - hsec);

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_era_r  <= s5_era_nxt;
      s5_remh_r <= s5_remh_nxt;
      s5_z_r    <= s4_z_r;
      s5_hour_r <= s4_hour_r;
    end
  end

  // ---------------- stage 6: day of era, minute ----------------
  logic [21:0] era_d;
  logic [24:0] prod_m;
  logic [17:0] s6_doe_nxt, s6_doe_r;
  logic [5:0]  s6_min_nxt, s6_min_r;
  logic [4:0]  s6_era_r;
  logic [11:0] s6_remh_r;
  logic [4:0]  s6_hour_r;

  assign era_d      = 22'(s5_era_r) * e2c_pkg::DAYS_ERA;
  assign s6_doe_nxt = 18'(s5_z_r - era_d);
  assign prod_m     = 25'(s5_remh_r) * 25'(e2c_pkg::RCP_MIN);
  assign s6_min_nxt = prod_m[23:18];

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_doe_r  <= s6_doe_nxt;
      s6_min_r  <= s6_min_nxt;
      s6_era_r  <= s5_era_r;
      s6_remh_r <= s5_remh_r;
      s6_hour_r <= s5_hour_r;
    end
  end

  // ---------------- stage 7: leap-day corrections, second ----------------
  logic [36:0] prod_a, prod_b;
  logic [11:0] msec;
  logic [7:0]  s7_a_nxt, s7_a_r;
  logic [2:0]  s7_b_nxt, s7_b_r;
  logic        s7_c_nxt, s7_c_r;
  logic [5:0]  s7_sec_nxt;
  logic [17:0] s7_doe_r;
  logic [4:0]  s7_era_r;
  logic [16:0] hms_nxt;
  logic [16:0] hms_r [6];   // stages 7..12

  assign prod_a     = 37'(s6_doe_r) * 37'(e2c_pkg::RCP_4Y);
  assign prod_b     = 37'(s6_doe_r) * 37'(e2c_pkg::RCP_100Y);
  assign s7_a_nxt   = prod_a[36:29];
  assign s7_b_nxt   = prod_b[36:34];
  assign s7_c_nxt   = (s6_doe_r == e2c_pkg::DAYS_ERA_LAST);
  assign msec       = 12'(s6_min_r) * e2c_pkg::SEC_MIN;
  assign s7_sec_nxt = 6'(s6_remh_r - msec);
  assign hms_nxt    = {s6_hour_r, s6_min_r, s7_sec_nxt};

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_a_r   <= s7_a_nxt;
      s7_b_r   <= s7_b_nxt;
      s7_c_r   <= s7_c_nxt;
      s7_doe_r <= s6_doe_r;
      s7_era_r <= s6_era_r;
      hms_r[0] <= hms_nxt;
      for (int i = 1; i < 6; i++) begin
        hms_r[i] <= hms_r[i-1];
      end
    end
  end

  // ---------------- stage 8: leap-free day count ----------------
  logic [17:0] s8_t_nxt, s8_t_r;
  logic [17:0] s8_doe_r;
  logic [4:0]  s8_era_r;

  assign s8_t_nxt = s7_doe_r - 18'(s7_a_r) + 18'(s7_b_r) - 18'(s7_c_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_t_r   <= s8_t_nxt;
      s8_doe_r <= s7_doe_r;
      s8_era_r <= s7_era_r;
    end
  end

  // ---------------- stage 9: year of era ----------------
  logic [36:0] prod_y;
  logic [9:0]  s9_yoe_nxt, s9_yoe_r;
  logic [17:0] s9_doe_r;
  logic [4:0]  s9_era_r;

  assign prod_y     = 37'(s8_t_r) * 37'(e2c_pkg::RCP_YEAR);
  assign s9_yoe_nxt = prod_y[36:27];

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_yoe_r <= s9_yoe_nxt;
      s9_doe_r <= s8_doe_r;
      s9_era_r <= s8_era_r;
    end
  end

  // ---------------- stage 10: day from March 1, base year, leap flag ----------------
  logic [1:0]  cent;
  logic [18:0] ydays;
  logic [8:0]  s10_dmar_nxt, s10_dmar_r;
  logic [13:0] s10_ybase_nxt, s10_ybase_r;
  logic        s10_leap_nxt, s10_leap_r;

  assign cent = 2'(s9_yoe_r >= 10'd100) + 2'(s9_yoe_r >= 10'd200) + 2'(s9_yoe_r >= 10'd300);
  assign ydays = 19'(s9_yoe_r) * e2c_pkg::DAYS_YEAR + 19'(s9_yoe_r[9:2]) - 19'(cent);
  assign s10_dmar_nxt  = 9'(19'(s9_doe_r) - ydays);
  assign s10_ybase_nxt = 14'(s9_era_r) * e2c_pkg::YEARS_ERA + 14'(s9_yoe_r);
  // Within an era, century years other than the era's first are common
  assign s10_leap_nxt  = (s9_yoe_r[1:0] == 2'd0) && (s9_yoe_r != 10'd100) &&
                         (s9_yoe_r != 10'd200) && (s9_yoe_r != 10'd300);

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_dmar_r  <= s10_dmar_nxt;
      s10_ybase_r <= s10_ybase_nxt;
      s10_leap_r  <= s10_leap_nxt;
    end
  end

  // ---------------- stage 11: month from March ----------------
  logic [11:0] mx;
  logic [24:0] prod_mp;
  logic [3:0]  s11_mp_nxt, s11_mp_r;
  logic [8:0]  s11_dmar_r;
  logic [13:0] s11_ybase_r;
  logic        s11_leap_r;

  assign mx         = 12'(s10_dmar_r) * 12'd5 + 12'd2;
  assign prod_mp    = 25'(mx) * 25'(e2c_pkg::RCP_MON);
  assign s11_mp_nxt = prod_mp[23:20];

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_mp_r    <= s11_mp_nxt;
      s11_dmar_r  <= s10_dmar_r;
      s11_ybase_r <= s10_ybase_r;
      s11_leap_r  <= s10_leap_r;
    end
  end

  // ---------------- stage 12: civil date ----------------
  logic       janfeb;
  logic [4:0] s12_dom_nxt, s12_dom_r;
  logic [3:0] s12_mon_nxt, s12_mon_r;
  logic [13:0] s12_year_nxt, s12_year_r;
  logic [8:0] s12_doy_nxt, s12_doy_r;

  // January and February belong to the following calendar year
  assign janfeb       = (s11_mp_r >= 4'd10);
  assign s12_dom_nxt  = 5'(s11_dmar_r - e2c_pkg::mar_start(s11_mp_r) + 9'd1);
  assign s12_mon_nxt  = janfeb ? (s11_mp_r - 4'd9) : (s11_mp_r + 4'd3);
  assign s12_year_nxt = s11_ybase_r + 14'(janfeb);
  assign s12_doy_nxt  = janfeb ? (s11_dmar_r - e2c_pkg::DOY_JAN_OFS)
                               : (s11_dmar_r + e2c_pkg::DOY_MAR_OFS + 9'(s11_leap_r));

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_dom_r  <= s12_dom_nxt;
      s12_mon_r  <= s12_mon_nxt;
      s12_year_r <= s12_year_nxt;
      s12_doy_r  <= s12_doy_nxt;
    end
  end

  // ---------------- stage 13: result register, drop date when out of range ----------------
  e2c_pkg::e2c_out_t out_nxt, out_r;
  logic              oor12;

  assign oor12 = oor_r[NS-2];

  always_comb begin
    out_nxt.year            = oor12 ? '0 : s12_year_r;
    out_nxt.month           = oor12 ? '0 : s12_mon_r;
    out_nxt.day_of_month    = oor12 ? '0 : s12_dom_r;
    out_nxt.day_of_year     = oor12 ? '0 : s12_doy_r;
    out_nxt.hour            = hms_r[5][16:12];
    out_nxt.minute          = hms_r[5][11:6];
    out_nxt.second          = hms_r[5][5:0];
    out_nxt.second_fraction = frac_r[NS-2];
    out_nxt.out_of_range    = oor12;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule
